>>> rtl/core/virtual_ip_binding_table_defines.svh
// Assertion macros shared by the binding table RTL.
// Depends on nothing; included by the top level.
`ifndef VIRTUAL_IP_BINDING_TABLE_DEFINES_SVH
`define VIRTUAL_IP_BINDING_TABLE_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define VIBT_ASSERT_IMP(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define VIBT_ASSERT_NEXT(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> rtl/core/vibt_pkg.sv
// Package for the virtual address binding table: payload structs and codes.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package vibt_pkg;
	localparam logic [1:0] CMD_LOOKUP = 2'd0;
	localparam logic [1:0] CMD_FIND   = 2'd1;
	localparam logic [1:0] CMD_TICK   = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_EXHAUSTED = 2'd2;

	localparam logic [1:0] REG_BASE     = 2'd0;
	localparam logic [1:0] REG_SIZE     = 2'd1;
	localparam logic [1:0] REG_LIFETIME = 2'd2;

	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] client_ip;
		logic [15:0] client_port;
		logic [15:0] user_tag;
		logic [31:0] query_address;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] bound_address;
		logic [31:0] found_ip;
		logic [15:0] found_port;
		logic [15:0] found_user;
	} res_t;
endpackage
`default_nettype wire

>>> rtl/core/vibt_slot_mem.sv
// Slot store: ip, port, user and remaining lifetime, one row per pool slot.
// Depends on nothing; one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module vibt_slot_mem #(
	parameter int Depth = 256,
	parameter int AW = 8
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [79:0]   wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [79:0]   rdata
);
	logic [79:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

>>> rtl/core/virtual_ip_binding_table.sv
// Top level of the virtual address binding table: sequencer, registers, valid bits.
// Depends on vibt_pkg, vibt_slot_mem and virtual_ip_binding_table_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "virtual_ip_binding_table_defines.svh"
// A command is taken when start is high and busy is low; busy then stays high
// until the edge that raises done, and the single result is shown for one
// cycle with done high. The receiver cannot stall, so the result must be
// captured in that cycle. Every slot row sits in one memory with one write
// port and one registered read port, visited one row at a time by a
// sequencer. A lookup first scans all POOL_CAPACITY rows for a matching live
// pair, issuing a read and then comparing for each row (stopping on a hit),
// and, failing that, walks the valid bits from the lowest-free hint to the
// first free slot below the configured size, one slot at a time. A tick
// visits every row with a read and, for a live row with a nonzero lifetime,
// a write-back of the decremented lifetime; a find issues one read and waits
// for it, and the unused command goes straight to S_DONE. Valid bits are
// flip-flops cleared by reset, so no clearing pass is needed after reset.
module virtual_ip_binding_table
	import vibt_pkg::*;
#(
	parameter int POOL_CAPACITY = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire cmd_t        cmd,
	output logic             busy,
	output logic             done,
	output res_t             res,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);
	localparam int AW = (POOL_CAPACITY > 1) ? $clog2(POOL_CAPACITY) : 1;
	localparam int CW = $clog2(POOL_CAPACITY + 1);
	localparam logic [CW-1:0] CAP = CW'(POOL_CAPACITY);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_MRD   = 7'b0000010,
		S_MCHK  = 7'b0000100,
		S_FREE  = 7'b0001000,
		S_FIND  = 7'b0010000,
		S_TICK  = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t state_q;
	cmd_t   cmd_q;
	res_t   res_q;
	logic   done_q;
	logic [31:0] base_q;
	logic [8:0]  size_q;
	logic [15:0] life_q;
	logic [CW-1:0] hint_q;
	logic [CW-1:0] idx_q;   // address issued to memory
	logic [CW-1:0] prev_q;  // address whose data is on rdata
	logic          pend_q;  // rdata valid for prev_q
	logic [POOL_CAPACITY-1:0] valid_q;

	logic        we;
	logic [AW-1:0] waddr, raddr;
	logic [79:0] wdata, rdata;
	logic [CW-1:0] eff_size;
	logic [31:0] qoff;
	logic [15:0] dec;

	assign pready = 1'b1;
	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign res    = res_q;
	assign eff_size = (int'(size_q) > POOL_CAPACITY) ? CAP : CW'(size_q);
	assign qoff = cmd_q.query_address - base_q;
	assign raddr = idx_q[AW-1:0];
	assign dec = rdata[15:0] - 16'd1;

	always_comb begin
		prdata = '0;
		unique case (paddr[3:2])
			REG_BASE:     prdata = base_q;
			REG_SIZE:     prdata = {23'd0, size_q};
			REG_LIFETIME: prdata = {16'd0, life_q};
			default:      prdata = '0;
		endcase
	end

	// Write port: new binding in S_FREE, lifetime write-back in S_TICK.
	always_comb begin
		we = 1'b0;
		waddr = prev_q[AW-1:0];
		wdata = {rdata[79:16], dec};
		if (state_q == S_FREE) begin
			we = (idx_q < eff_size) && !valid_q[idx_q[AW-1:0]];
			waddr = idx_q[AW-1:0];
			wdata = {cmd_q.client_ip, cmd_q.client_port, cmd_q.user_tag, life_q};
		end else if (state_q == S_TICK) begin
			we = pend_q && valid_q[prev_q[AW-1:0]] && (rdata[15:0] != 16'd0);
		end
	end

	vibt_slot_mem #(.Depth(POOL_CAPACITY), .AW(AW)) u_mem (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			size_q <= 9'd256;
			life_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_BASE:     base_q <= pwdata;
				REG_SIZE:     size_q <= pwdata[8:0];
				REG_LIFETIME: life_q <= pwdata[15:0];
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q   <= '0;
			res_q   <= '0;
			done_q  <= 1'b0;
			hint_q  <= '0;
			valid_q <= '0;
			idx_q   <= '0;
			prev_q  <= '0;
			pend_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q <= cmd;
						res_q <= '0;
						idx_q <= '0;
						pend_q <= 1'b0;
						if (cmd.command == CMD_LOOKUP) begin
							state_q <= S_MRD;
						end else if (cmd.command == CMD_FIND) begin
							state_q <= S_FIND;
						end else if (cmd.command == CMD_TICK) begin
							state_q <= S_TICK;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_MRD: begin
					// address idx_q issued this cycle; compare next
					state_q <= S_MCHK;
				end
				S_MCHK: begin
					if (valid_q[idx_q[AW-1:0]] && rdata[79:48] == cmd_q.client_ip
						&& rdata[47:32] == cmd_q.client_port) begin
						res_q.bound_address <= base_q + 32'(idx_q);
						state_q <= S_DONE;
					end else if (idx_q == CAP - 1'b1) begin
						idx_q <= hint_q;
						state_q <= S_FREE;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= S_MRD;
					end
				end
				S_FREE: begin
					if (idx_q >= eff_size) begin
						hint_q <= eff_size;
						res_q.status <= ST_EXHAUSTED;
						state_q <= S_DONE;
					end else if (!valid_q[idx_q[AW-1:0]]) begin
						hint_q <= idx_q;
						valid_q[idx_q[AW-1:0]] <= 1'b1;
						res_q.bound_address <= base_q + 32'(idx_q);
						state_q <= S_DONE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_FIND: begin
					if (!pend_q) begin
						idx_q <= (qoff < 32'(POOL_CAPACITY)) ? CW'(qoff) : '0;
						pend_q <= 1'b1;
						prev_q <= '0;
					end else if (prev_q == '0) begin
						prev_q <= CW'(1); // wait for registered read
					end else begin
						if (qoff < 32'(POOL_CAPACITY) && valid_q[idx_q[AW-1:0]]) begin
							res_q.found_ip   <= rdata[79:48];
							res_q.found_port <= rdata[47:32];
							res_q.found_user <= rdata[31:16];
						end else begin
							res_q.status <= ST_NOT_FOUND;
						end
						pend_q <= 1'b0;
						state_q <= S_DONE;
					end
				end
				S_TICK: begin
					if (pend_q && valid_q[prev_q[AW-1:0]] && rdata[15:0] == 16'd1) begin
						valid_q[prev_q[AW-1:0]] <= 1'b0;
						if (prev_q < hint_q) begin
							hint_q <= prev_q;
						end
					end
					if (idx_q == CAP) begin
						pend_q <= 1'b0;
						state_q <= S_DONE;
					end else begin
						prev_q <= idx_q;
						pend_q <= 1'b1;
						idx_q <= idx_q + 1'b1;
					end
				end
				S_DONE: begin
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`VIBT_ASSERT_NEXT(a_done_pulse, clk, arst_n, done_q, !done_q)
	`VIBT_ASSERT_IMP(a_done_idle, clk, arst_n, done_q, state_q == S_IDLE)
	`VIBT_ASSERT_IMP(a_hint_range, clk, arst_n, 1'b1, hint_q <= CAP)
endmodule
`default_nettype wire
